[rtl/square_matrix_multiply_top_assert.svh]
// Assertion macros for the square matrix multiply RTL.
`ifndef SQUARE_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define SQMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SQMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SQMM_ASSERT(lbl, prop, msg)
`define SQMM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/sqmm_pkg.sv]
`default_nettype none
package sqmm_pkg;

  localparam int MAX_ORDER_DEF = 4;
  localparam int DATA_W        = 32;
  localparam int PROD_W        = 64;
  localparam int FRAC_W        = 16;
  localparam int SIZE_W        = 3;
  localparam logic [SIZE_W-1:0] SIZE_RST = 3'd4;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_element;
    logic signed [DATA_W-1:0] right_element;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] product_element;
    logic                     last_element;
  } out_word_t;

  // travels with each multiply through the datapath
  typedef struct packed {
    logic first_k;
    logic last_k;
    logic last_elem;
  } pipe_tag_t;

  typedef struct packed {
    logic      wr_en;
    logic      rd_en;
    pipe_tag_t tag;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_sts_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } ctrl_state_t;

endpackage
`default_nettype wire

[rtl/sqmm_datapath.sv]
`default_nettype none
module sqmm_datapath #(
  parameter int MAX_ORDER = sqmm_pkg::MAX_ORDER_DEF,
  localparam int DEPTH = MAX_ORDER * MAX_ORDER,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sqmm_pkg::dp_cmd_t cmd,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [AW-1:0]     rd_a_addr,
  input  wire logic [AW-1:0]     rd_b_addr,
  input  wire sqmm_pkg::in_word_t in_data,
  output sqmm_pkg::dp_sts_t      sts,
  output logic                   out_strobe,
  output sqmm_pkg::out_word_t    out_data
);
  import sqmm_pkg::*;

  localparam int SW = PROD_W + ((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 0);

  logic signed [DATA_W-1:0] left_mem  [DEPTH];
  logic signed [DATA_W-1:0] right_mem [DEPTH];

  logic signed [DATA_W-1:0] a_rd_r, b_rd_r;
  pipe_tag_t                tag1_r, tag2_r;
  logic                     v1_r, v2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SW-1:0]     acc_r;
  logic signed [SW-1:0]     sum_nxt;
  logic signed [SW-1:0]     shifted;
  logic [SW-32:0]           hi_bits;
  logic signed [DATA_W-1:0] sat_val;
  logic                     out_strobe_r;
  out_word_t                out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      left_mem[wr_addr]  <= in_data.left_element;
      right_mem[wr_addr] <= in_data.right_element;
    end
    a_rd_r <= left_mem[rd_a_addr];
    b_rd_r <= right_mem[rd_b_addr];
    tag1_r <= cmd.tag;
    prod_r <= PROD_W'(a_rd_r) * PROD_W'(b_rd_r);
    tag2_r <= tag1_r;
    if (v2_r) begin
      acc_r <= sum_nxt;
    end
    if (v2_r && tag2_r.last_k) begin
      out_data_r.product_element <= sat_val;
      out_data_r.last_element    <= tag2_r.last_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= cmd.rd_en;
      v2_r         <= v1_r;
      out_strobe_r <= v2_r && tag2_r.last_k;
    end
  end

  // full-precision sum, floor shift, then clamp to 32 bits
  always_comb begin
    sum_nxt = tag2_r.first_k ? SW'(prod_r) : SW'(acc_r + SW'(prod_r));
    shifted = sum_nxt >>> FRAC_W;
    hi_bits = shifted[SW-1:DATA_W-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      sat_val = shifted[DATA_W-1:0];
    end else if (hi_bits[SW-32]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign sts.pipe_busy = v1_r || v2_r;
  assign out_strobe    = out_strobe_r;
  assign out_data      = out_data_r;

endmodule
`default_nettype wire

[rtl/sqmm_ctrl.sv]
`default_nettype none
`include "square_matrix_multiply_top_assert.svh"
module sqmm_ctrl #(
  parameter int MAX_ORDER = sqmm_pkg::MAX_ORDER_DEF,
  localparam int DEPTH = MAX_ORDER * MAX_ORDER,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [sqmm_pkg::SIZE_W-1:0] cfg_data,
  input  wire sqmm_pkg::dp_sts_t           sts,
  output sqmm_pkg::dp_cmd_t                cmd,
  output logic [AW-1:0]                    wr_addr,
  output logic [AW-1:0]                    rd_a_addr,
  output logic [AW-1:0]                    rd_b_addr
);
  import sqmm_pkg::*;

  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  ctrl_state_t       state_r, state_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [CW-1:0]     load_cnt_r, load_cnt_nxt;
  logic [IW-1:0]     i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [AW-1:0]     a_addr_r, a_addr_nxt, b_addr_r, b_addr_nxt, b_base_r, b_base_nxt;
  logic [OW-1:0]     ord;
  logic [IW-1:0]     ord_m1;
  logic [CW-1:0]     total;
  logic              accept, cfg_fire;

  // order n: zero reads as one, above the maximum saturates
  always_comb begin
    if (size_r == '0) begin
      ord = OW'(1);
    end else if (int'(size_r) > MAX_ORDER) begin
      ord = OW'(MAX_ORDER);
    end else begin
      ord = OW'(size_r);
    end
    ord_m1 = IW'(ord - OW'(1));
    total  = CW'(CW'(ord) * CW'(ord));
  end

  assign busy      = (state_r != ST_LOAD);
  // a size write never lands on the same edge as a load word
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      size_r     <= SIZE_RST;
      load_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      size_r     <= size_nxt;
      load_cnt_r <= load_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    a_addr_r <= a_addr_nxt;
    b_addr_r <= b_addr_nxt;
    b_base_r <= b_base_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    size_nxt     = size_r;
    load_cnt_nxt = load_cnt_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    a_addr_nxt   = a_addr_r;
    b_addr_nxt   = b_addr_r;
    b_base_nxt   = b_base_r;
    cmd.wr_en    = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.tag.first_k   = (k_r == '0);
    cmd.tag.last_k    = (k_r == ord_m1);
    cmd.tag.last_elem = (i_r == ord_m1) && (j_r == ord_m1);

    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          cmd.wr_en = 1'b1;
          if (load_cnt_r == CW'(total - CW'(1))) begin
            load_cnt_nxt = '0;
            state_nxt    = ST_RUN;
            i_nxt        = '0;
            j_nxt        = '0;
            k_nxt        = '0;
            a_addr_nxt   = '0;
            b_addr_nxt   = '0;
            b_base_nxt   = '0;
          end else begin
            load_cnt_nxt = CW'(load_cnt_r + CW'(1));
          end
        end
      end
      ST_RUN: begin
        // a index k*n+j, b index i*n+k, kept as running sums
        cmd.rd_en = 1'b1;
        if (k_r != ord_m1) begin
          k_nxt      = IW'(k_r + IW'(1));
          a_addr_nxt = AW'(a_addr_r + AW'(ord));
          b_addr_nxt = AW'(b_addr_r + AW'(1));
        end else begin
          k_nxt = '0;
          if (j_r != ord_m1) begin
            j_nxt      = IW'(j_r + IW'(1));
            a_addr_nxt = AW'(AW'(j_r) + AW'(1));
            b_addr_nxt = b_base_r;
          end else begin
            j_nxt      = '0;
            a_addr_nxt = '0;
            if (i_r != ord_m1) begin
              i_nxt      = IW'(i_r + IW'(1));
              b_base_nxt = AW'(b_base_r + AW'(ord));
              b_addr_nxt = AW'(b_base_r + AW'(ord));
            end else begin
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    // a size write restarts loading at element 0
    if (cfg_fire) begin
      size_nxt     = cfg_data;
      load_cnt_nxt = '0;
    end
  end

  assign wr_addr   = load_cnt_r[AW-1:0];
  assign rd_a_addr = a_addr_r;
  assign rd_b_addr = b_addr_r;

  `SQMM_ASSERT(a_load_in_range, (state_r == ST_LOAD) |-> (load_cnt_r < total), "load count past matrix size")
  `SQMM_ASSERT(a_idx_in_range, (state_r == ST_RUN) |-> ((i_r <= ord_m1) && (j_r <= ord_m1) && (k_r <= ord_m1)), "compute index past order")
  `SQMM_ASSERT(a_full_starts_run, (accept && !cfg_fire && (load_cnt_r == CW'(total - CW'(1)))) |=> (state_r == ST_RUN), "full matrix did not start compute")
  `SQMM_ASSERT_ALWAYS(a_reset_to_load, !rst_n |=> (state_r == ST_LOAD), "reset did not return to load")

endmodule
`default_nettype wire

[rtl/square_matrix_multiply_top.sv]
`default_nettype none
// Square matrix multiplier, signed Q16.16, order n = 1..MAX_ORDER set by the size
// register (0 acts as 1, values above MAX_ORDER saturate; a write restarts loading).
// The size register takes a write only while busy and start are both low.
// Each start with busy low loads one word holding one element of each matrix,
// column-major, one cycle per word. The word that completes the n*n load raises busy,
// and the single 32x32 multiplier with its accumulator then sums n products for each
// of the n*n results, one product per cycle, with busy held through the last strobe.
// Results come out in index order, each on out_data for exactly one cycle under
// out_strobe, the last one flagged; there is no backpressure, so the receiver must
// take every strobed word. Sums are exact, floored by 2^16 and saturated to 32 bits.
module square_matrix_multiply_top #(
  parameter int MAX_ORDER = sqmm_pkg::MAX_ORDER_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire sqmm_pkg::in_word_t          in_data,
  output logic                             out_strobe,
  output sqmm_pkg::out_word_t              out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [sqmm_pkg::SIZE_W-1:0] cfg_data
);
  import sqmm_pkg::*;

  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;

  sqmm_ctrl #(
    .MAX_ORDER(MAX_ORDER)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr)
  );

  sqmm_datapath #(
    .MAX_ORDER(MAX_ORDER)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_a_addr  (rd_a_addr),
    .rd_b_addr  (rd_b_addr),
    .in_data    (in_data),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import sqmm_pkg::*;

  localparam int ORDER_MAX = MAX_ORDER_DEF;
  localparam int STORE_WORDS = ORDER_MAX * ORDER_MAX;
  localparam int RANDOM_PAIRS = 250;
  localparam int SETTLE_CYCLES = ORDER_MAX * ORDER_MAX * ORDER_MAX + 8;
  localparam int STALL_LIMIT = 2000;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [79:0] SUM_MAX = 80'sh7FFF_FFFF;
  localparam logic signed [79:0] SUM_MIN = -80'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_data = '0;
  logic out_strobe;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SIZE_W-1:0] cfg_data = '0;

  // matrix state mirrored for prediction
  logic signed [DATA_W-1:0] left_mat [STORE_WORDS];
  logic signed [DATA_W-1:0] right_mat [STORE_WORDS];
  int unsigned pairs_loaded = 0;
  logic [SIZE_W-1:0] size_reg = SIZE_RST;

  out_word_t pending_products[$];
  out_word_t oldest_product;

  int error_count = 0;
  int pairs_sent = 0;
  int products_checked = 0;
  int size_writes = 0;
  logic [7:0] sizes_seen = '0;
  int burst_left = 0;
  int stall_cycles = 0;

  always #5 clk = ~clk;

  square_matrix_multiply_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  function automatic int unsigned active_order(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > ORDER_MAX) return ORDER_MAX;
    return s;
  endfunction

  // exact dot product, floored by 2^16, saturated
  function automatic logic signed [DATA_W-1:0] dot_q16(int unsigned n, int unsigned row,
                                                     int unsigned col);
    logic signed [79:0] acc;
    logic signed [PROD_W-1:0] prod;
    acc = '0;
    for (int unsigned k = 0; k < n; k++) begin
      prod = left_mat[(k * n + row) % STORE_WORDS] * right_mat[(col * n + k) % STORE_WORDS];
      acc += prod;
    end
    acc = acc >>> FRAC_W;
    if (acc > SUM_MAX) return Q_MAX;
    if (acc < SUM_MIN) return Q_MIN;
    return acc[DATA_W-1:0];
  endfunction

  task automatic load_and_multiply(in_word_t w);
    int unsigned n;
    int unsigned total;
    int unsigned slot;
    out_word_t word;
    n = active_order(size_reg);
    total = n * n;
    slot = pairs_loaded % STORE_WORDS;
    left_mat[slot] = w.left_element;
    right_mat[slot] = w.right_element;
    pairs_loaded = (slot + 1) & 31;
    if (pairs_loaded >= total) begin
      pairs_loaded = 0;
      for (int unsigned i = 0; i < n; i++) begin
        for (int unsigned j = 0; j < n; j++) begin
          word.product_element = dot_q16(n, j, i);
          word.last_element = (i * n + j + 1 == total);
          pending_products.push_back(word);
        end
      end
    end
  endtask

  function automatic in_word_t make_pair(logic signed [DATA_W-1:0] l,
                                         logic signed [DATA_W-1:0] r);
    in_word_t w;
    w.left_element = l;
    w.right_element = r;
    return w;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_element();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      7, 8: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      default: begin
        case ($urandom_range(0, 6))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          3: return '1;
          4: return 32'sd1;
          5: return Q_ONE;
          default: return -Q_ONE;
        endcase
      end
    endcase
  endfunction

  // sender side: bursts with random gaps; start stays high across a burst
  task automatic send_pair(in_word_t w);
    if (burst_left == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 70)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    load_and_multiply(w);
    pairs_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
  endtask

  // a size write also drops any partial load
  task automatic write_size(logic [SIZE_W-1:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = v;
    pairs_loaded = 0;
    size_writes++;
    sizes_seen[v] = 1'b1;
  endtask

  task automatic test_order_limits();
    // size 0 acts as order 1
    write_size(3'd0);
    send_pair(make_pair(Q_MIN, Q_MIN));
    send_pair(make_pair('1, 32'sd1));
    write_size(3'd1);
    send_pair(make_pair(Q_MAX, Q_MIN));
  endtask

  task automatic test_load_restart();
    write_size(3'd7);
    for (int k = 0; k < 3; k++) send_pair(make_pair(rand_element(), rand_element()));
    write_size(3'd2);
    send_pair(make_pair(Q_MAX, Q_MAX));
    send_pair(make_pair(Q_MIN, Q_MAX));
    send_pair(make_pair(32'sd1, Q_MIN));
    send_pair(make_pair('1, Q_ONE));
  endtask

  task automatic test_order_three();
    write_size(3'd3);
    for (int k = 0; k < 9; k++)
      send_pair(make_pair(Q_ONE * (k + 1) + k, 32'sh8000 - Q_ONE * k));
  endtask

  task automatic test_random_matrices();
    int target;
    int unsigned n;
    int unsigned cut;
    target = pairs_sent + RANDOM_PAIRS;
    while (pairs_sent < target) begin
      write_size(3'($urandom_range(0, 7)));
      n = active_order(size_reg);
      repeat ($urandom_range(1, 3)) begin
        // now and then a partial load, dropped by the next size write
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n * n - 1) : n * n;
        for (int unsigned k = 0; k < cut; k++)
          send_pair(make_pair(rand_element(), rand_element()));
        if (cut < n * n) break;
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_products.size() == 0) begin
        $error("unexpected product word %h", out_data);
        error_count++;
      end else begin
        oldest_product = pending_products.pop_front();
        products_checked++;
        if (out_data.product_element !== oldest_product.product_element) begin
          $error("product_element: expected %h, actual %h",
                 oldest_product.product_element, out_data.product_element);
          error_count++;
        end
        if (out_data.last_element !== oldest_product.last_element) begin
          $error("last_element: expected %b, actual %b",
                 oldest_product.last_element, out_data.last_element);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_order_limits();
    test_load_restart();
    test_order_three();
    test_random_matrices();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("summary: %0d element pairs sent, %0d product words checked",
             pairs_sent, products_checked);
    $display("summary: %0d size writes, size codes seen %b", size_writes, sizes_seen);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/sqmm_pkg.sv
rtl/sqmm_datapath.sv
rtl/sqmm_ctrl.sv
rtl/square_matrix_multiply_top.sv
bench/tb_top.sv
